// ----- src/qamd_pkg.sv -----
// Package for the QAM mapper / hard-decision demapper.
// Holds sample and mode types, the Q3.12 level tables and the per-axis slicer.
// No dependencies; used by the top level and its checker.
package qamd_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int SYMBOL_WIDTH = 6;
    localparam int LEVEL_WIDTH  = 3;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [SYMBOL_WIDTH-1:0]        symbol_t;
    typedef logic [LEVEL_WIDTH-1:0]         level_idx_t;
    typedef logic signed [SAMPLE_WIDTH+1:0] wide_sample_t;

    // Constellation select; the unused code decodes as 64-QAM
    typedef enum logic [1:0] {
        MODE_QPSK  = 2'd0,
        MODE_16QAM = 2'd1,
        MODE_64QAM = 2'd2
    } mode_t;

    typedef enum logic {
        OP_MAP   = 1'b0,
        OP_DEMAP = 1'b1
    } op_t;

    // Level magnitudes in Q3.12: |L| * 4096 / sqrt(N), rounded to nearest
    localparam sample_t QPSK_L1  = 16'sd2896;
    localparam sample_t QAM16_L1 = 16'sd1295;
    localparam sample_t QAM16_L3 = 16'sd3886;
    localparam sample_t QAM64_L1 = 16'sd632;
    localparam sample_t QAM64_L3 = 16'sd1896;
    localparam sample_t QAM64_L5 = 16'sd3160;
    localparam sample_t QAM64_L7 = 16'sd4424;

    // Largest magnitude of any level, for range checks
    localparam sample_t LEVEL_MAX = QAM64_L7;

    // Axis level for level index k, lowest level first
    function automatic sample_t level_value(mode_t mode, level_idx_t k);
        sample_t v;
        case (mode)
            MODE_QPSK:
            begin
                v = k[0] ? QPSK_L1 : -QPSK_L1;
            end
            MODE_16QAM:
            begin
                case (k[1:0])
                    2'd0:    v = -QAM16_L3;
                    2'd1:    v = -QAM16_L1;
                    2'd2:    v = QAM16_L1;
                    default: v = QAM16_L3;
                endcase
            end
            default:
            begin
                case (k)
                    3'd0:    v = -QAM64_L7;
                    3'd1:    v = -QAM64_L5;
                    3'd2:    v = -QAM64_L3;
                    3'd3:    v = -QAM64_L1;
                    3'd4:    v = QAM64_L1;
                    3'd5:    v = QAM64_L3;
                    3'd6:    v = QAM64_L5;
                    default: v = QAM64_L7;
                endcase
            end
        endcase
        return v;
    endfunction

    // Highest level index on one axis
    function automatic level_idx_t level_top(mode_t mode);
        level_idx_t t;
        case (mode)
            MODE_QPSK:  t = 3'd1;
            MODE_16QAM: t = 3'd3;
            default:    t = 3'd7;
        endcase
        return t;
    endfunction

    function automatic wide_sample_t widen(sample_t a);
        return {{2{a[SAMPLE_WIDTH-1]}}, a};
    endfunction

    // Nearest level on one axis. Moving up to level k needs 2x strictly
    // above the sum of levels k-1 and k, so ties stay on the lower level.
    function automatic level_idx_t slice_axis(mode_t mode, sample_t x);
        wide_sample_t x2;
        wide_sample_t mid;
        level_idx_t   top;
        level_idx_t   cnt;
        x2  = {x[SAMPLE_WIDTH-1], x, 1'b0};
        top = level_top(mode);
        cnt = '0;
        for (int k = 1; k < (1 << LEVEL_WIDTH); k++)
        begin
            mid = widen(level_value(mode, LEVEL_WIDTH'(k - 1)))
                + widen(level_value(mode, LEVEL_WIDTH'(k)));
            if ((LEVEL_WIDTH'(k) <= top) && (x2 > mid))
                cnt = cnt + 3'd1;
        end
        return cnt;
    endfunction

endpackage

// ----- src/qam_mapper_demapper.sv -----
// QAM mapper and hard-decision demapper, QPSK / 16-QAM / 64-QAM, Q3.12.
// Depends on qamd_pkg for types, level tables and the axis slicer.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+------------------------------------
//  in      | in_valid / in_stall  | op, symbol_bits, rx_i, rx_q
//  out     | out_valid / out_stall| point_i, point_q, decided_bits
//  cfg     | cfg_wr_en            | cfg_wr_data (mode)
//
// One item per cycle sustained while out_stall is low. Each item passes through the
// input register, then the result register after the table lookup
// and the seven-comparator slicer per axis.
// Reset clears both valid flags and sets mode to QPSK.
// A stalled result holds in the result register while one more item is
// taken into the input register; in_stall rises only once both are full.
module qam_mapper_demapper (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_wr_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              op,
    input  qamd_pkg::symbol_t symbol_bits,
    input  qamd_pkg::sample_t rx_i,
    input  qamd_pkg::sample_t rx_q,
    output logic              out_valid,
    input  logic              out_stall,
    output qamd_pkg::sample_t point_i,
    output qamd_pkg::sample_t point_q,
    output qamd_pkg::symbol_t decided_bits
);
    import qamd_pkg::*;

    mode_t      mode_reg;
    logic       in_valid_reg;
    op_t        op_reg;
    symbol_t    bits_reg;
    sample_t    rx_i_reg;
    sample_t    rx_q_reg;
    logic       out_valid_reg;
    sample_t    point_i_reg;
    sample_t    point_q_reg;
    symbol_t    decided_reg;

    logic       out_adv;
    logic       in_adv;
    level_idx_t ii;
    level_idx_t qi;
    symbol_t    idx;
    sample_t    point_i_next;
    sample_t    point_q_next;
    symbol_t    decided_next;

    // Advance each stage when the one after it can take its item
    assign out_adv  = !out_valid_reg || !out_stall;
    assign in_adv   = !in_valid_reg || out_adv;
    assign in_stall = !in_adv;

    // Mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_QPSK;
        else if (cfg_wr_en)
            mode_reg <= mode_t'(cfg_wr_data);
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_adv)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_adv && in_valid)
        begin
            op_reg   <= op_t'(op);
            bits_reg <= symbol_bits;
            rx_i_reg <= rx_i;
            rx_q_reg <= rx_q;
        end
    end

    // Pick axis levels: split the index for map, slice the sample for demap
    always_comb
    begin
        ii  = '0;
        qi  = '0;
        idx = bits_reg;
        case (op_reg)
            OP_MAP:
            begin
                case (mode_reg)
                    MODE_QPSK:
                    begin
                        ii = {2'b00, bits_reg[1]};
                        qi = {2'b00, bits_reg[0]};
                    end
                    MODE_16QAM:
                    begin
                        ii = {1'b0, bits_reg[1:0]};
                        qi = {1'b0, bits_reg[3:2]};
                    end
                    default:
                    begin
                        ii = bits_reg[2:0];
                        qi = bits_reg[5:3];
                    end
                endcase
            end
            default:
            begin
                ii = slice_axis(mode_reg, rx_i_reg);
                qi = slice_axis(mode_reg, rx_q_reg);
                case (mode_reg)
                    MODE_QPSK:  idx = {4'b0000, ii[0], qi[0]};
                    MODE_16QAM: idx = {2'b00, qi[1:0], ii[1:0]};
                    default:    idx = {qi, ii};
                endcase
            end
        endcase
        point_i_next = level_value(mode_reg, ii);
        point_q_next = level_value(mode_reg, qi);
        decided_next = idx;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_adv)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && in_valid_reg)
        begin
            point_i_reg <= point_i_next;
            point_q_reg <= point_q_next;
            decided_reg <= decided_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign point_i      = point_i_reg;
    assign point_q      = point_q_reg;
    assign decided_bits = decided_reg;

endmodule

// ----- src/qamd_checker.sv -----
// Port-level checker for qam_mapper_demapper, bound to the top level.
// Depends on qamd_pkg for sample types and the largest level magnitude.
module qamd_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input qamd_pkg::sample_t point_i,
    input qamd_pkg::sample_t point_q,
    input qamd_pkg::symbol_t decided_bits
);
    import qamd_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(point_i)
            && $stable(point_q) && $stable(decided_bits))
        else $error("stalled result changed");

    // Clear results during reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // Stall the input only when a result is waiting and stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with output free");

    // Keep every output point on a nonzero level inside the 64-QAM span
    a_point_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> point_i != '0 && point_q != '0
            && point_i <= LEVEL_MAX && point_i >= -LEVEL_MAX
            && point_q <= LEVEL_MAX && point_q >= -LEVEL_MAX)
        else $error("output point off the level grid");

endmodule

bind qam_mapper_demapper qamd_checker u_qamd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .point_i      (point_i),
    .point_q      (point_q),
    .decided_bits (decided_bits)
);
